// File: sv/heading_pi_rudder_controller_macros.svh
// Assertion macros for the heading PI rudder controller.
`ifndef HEADING_PI_RUDDER_CONTROLLER_MACROS_SVH
`define HEADING_PI_RUDDER_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is high.
`define HPR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hpr assertion failed");

// Clocked property that also holds during reset.
`define HPR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("hpr assertion failed");

`else

`define HPR_ASSERT(lbl, clk, rst, prop)
`define HPR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: sv/hpr_pkg.sv
package hpr_pkg;

   localparam int HEADING_W   = 9;
   localparam int ANGLE_W     = 9;
   localparam int GAIN_W      = 16;
   localparam int CENTRE_W    = 8;
   localparam int LIMIT_W     = 7;
   localparam int DECAY_W     = 9;
   localparam int INTEG_W     = 24;
   localparam int FRAC_W      = 8;
   localparam int DIFF_W      = HEADING_W + 2;
   localparam int ERR_W       = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int PPROD_W     = GAIN_W + ERR_W;
   localparam int IPROD_W     = GAIN_W + INTEG_W;
   localparam int DRIVE_W     = IPROD_W + 1;
   localparam int ROUND_SHIFT = 2 * FRAC_W;
   localparam int RND_W       = DRIVE_W - ROUND_SHIFT + 1;
   localparam int CALC_W      = RND_W + 1;
   localparam int DPROD_W     = INTEG_W + DECAY_W + 1;
   localparam int DQ_W        = DPROD_W - FRAC_W;

   localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(180);
   localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(360);

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   localparam logic signed [GAIN_W-1:0]  P_GAIN_RST   = GAIN_W'(256);
   localparam logic signed [GAIN_W-1:0]  I_GAIN_RST   = GAIN_W'(26);
   localparam logic [CENTRE_W-1:0]       CENTRE_RST   = CENTRE_W'(90);
   localparam logic [LIMIT_W-1:0]        LIMIT_RST    = LIMIT_W'(45);
   localparam logic [DECAY_W-1:0]        DECAY_RST    = DECAY_W'(243);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_P_GAIN           = 3'd0,
      CSR_I_GAIN           = 3'd1,
      CSR_RUDDER_CENTRE    = 3'd2,
      CSR_DEFLECTION_LIMIT = 3'd3,
      CSR_DECAY_FACTOR     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [HEADING_W-1:0] measured_heading;
      logic [HEADING_W-1:0] target_heading;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] rudder_angle;
      logic               limited;
   } rsp_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] p_gain;
      logic signed [GAIN_W-1:0] i_gain;
      logic [CENTRE_W-1:0]      rudder_centre;
      logic [LIMIT_W-1:0]       deflection_limit;
      logic [DECAY_W-1:0]       decay_factor;
   } cfg_type;

endpackage

// File: sv/hpr_front.sv
`include "heading_pi_rudder_controller_macros.svh"

module hpr_front
   import hpr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  req_type                    item,
   input  logic                       advance,
   output logic signed [PPROD_W-1:0]  p_prod,
   output logic signed [IPROD_W-1:0]  i_prod
);

   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [DIFF_W-1:0]  wrapped;
   logic signed [ERR_W-1:0]   err;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_acc;
   logic signed [DPROD_W-1:0] decay_prod;
   logic signed [DPROD_W-1:0] decay_bias;
   logic signed [DQ_W-1:0]    decay_q;

   always_comb begin
      diff = $signed({2'b00, item.target_heading}) - $signed({2'b00, item.measured_heading});
      if (diff > HALF_TURN) begin
         wrapped = diff - FULL_TURN;
      end else if (diff < -HALF_TURN) begin
         wrapped = diff + FULL_TURN;
      end else begin
         wrapped = diff;
      end
      err = ERR_W'(-wrapped);

      integ_sum = (INTEG_W+1)'(integ_ff) + (INTEG_W+1)'($signed({err, {FRAC_W{1'b0}}}));
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_acc = integ_sum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_acc = integ_sum[INTEG_W-1:0];
      end

      p_prod = cfg.p_gain * err;
      i_prod = cfg.i_gain * integ_acc;

      // leak, truncated toward zero
      decay_prod = integ_acc * $signed({1'b0, cfg.decay_factor});
      decay_bias = decay_prod[DPROD_W-1] ? DPROD_W'((1 << FRAC_W) - 1) : '0;
      decay_q    = DQ_W'((decay_prod + decay_bias) >>> FRAC_W);
      if (decay_q[DQ_W-1:INTEG_W-1] != {(DQ_W-INTEG_W+1){decay_q[DQ_W-1]}}) begin
         integ_in = decay_q[DQ_W-1] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_in = decay_q[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (advance) begin
         integ_ff <= integ_in;
      end
   end

   `HPR_ASSERT(a_integ_hold, clock, reset, !advance |=> $stable(integ_ff))

endmodule

// File: sv/hpr_back.sv
module hpr_back
   import hpr_pkg::*;
(
   input  cfg_type                    cfg,
   input  logic signed [PPROD_W-1:0]  p_prod,
   input  logic signed [IPROD_W-1:0]  i_prod,
   output rsp_type                    result
);

   logic signed [DRIVE_W-1:0] drive;
   logic [DRIVE_W-1:0]        mag;
   logic [DRIVE_W-1:0]        mag_rnd;
   logic signed [RND_W-1:0]   rnd;
   logic signed [CALC_W-1:0]  angle;
   logic signed [CALC_W-1:0]  hi;
   logic signed [CALC_W-1:0]  lo;

   always_comb begin
      drive = DRIVE_W'($signed({p_prod, {FRAC_W{1'b0}}})) + DRIVE_W'(i_prod);
      mag   = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);
      mag_rnd = mag + DRIVE_W'(1 << (ROUND_SHIFT - 1));
      rnd = $signed({1'b0, mag_rnd[DRIVE_W-1:ROUND_SHIFT]});
      if (drive[DRIVE_W-1]) begin
         rnd = -rnd;
      end

      angle = $signed(CALC_W'(cfg.rudder_centre)) + CALC_W'(rnd);
      hi    = $signed(CALC_W'(cfg.rudder_centre) + CALC_W'(cfg.deflection_limit));
      if (cfg.rudder_centre >= CENTRE_W'(cfg.deflection_limit)) begin
         lo = $signed(CALC_W'(cfg.rudder_centre) - CALC_W'(cfg.deflection_limit));
      end else begin
         lo = '0;
      end

      if (angle > hi) begin
         result.rudder_angle = ANGLE_W'(hi);
         result.limited      = 1'b1;
      end else if (angle < lo) begin
         result.rudder_angle = ANGLE_W'(lo);
         result.limited      = 1'b1;
      end else begin
         result.rudder_angle = ANGLE_W'(angle);
         result.limited      = 1'b0;
      end
   end

endmodule

// File: sv/heading_pi_rudder_controller.sv
// Heading PI rudder controller with leaky integrator.
// rsp_valid rises once an accepted item has passed the product and result registers.
// Throughput: one item per cycle unless rsp_ready stalls the output; input, product and result registers form the pipe.
// Integrator feedback closes through the decay multiplier into the integrator register.
// Synchronous active-high reset: gains and limits to defaults, integrator to zero, pipe empty.
`include "heading_pi_rudder_controller_macros.svh"

module heading_pi_rudder_controller
   import hpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                   cfg_ff;
   req_type                   s1_item_ff;
   logic                      s1_valid_ff;
   logic signed [PPROD_W-1:0] p_prod_ff;
   logic signed [IPROD_W-1:0] i_prod_ff;
   logic                      s2_valid_ff;
   rsp_type                   rsp_ff;
   logic                      rsp_valid_ff;

   logic signed [PPROD_W-1:0] p_prod_in;
   logic signed [IPROD_W-1:0] i_prod_in;
   rsp_type                   rsp_in;
   logic                      out_ready;
   logic                      s2_ready;
   logic                      s1_fire;
   logic                      s2_fire;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign s1_fire   = s1_valid_ff && s2_ready;
   assign s2_fire   = s2_valid_ff && out_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain           <= P_GAIN_RST;
         cfg_ff.i_gain           <= I_GAIN_RST;
         cfg_ff.rudder_centre    <= CENTRE_RST;
         cfg_ff.deflection_limit <= LIMIT_RST;
         cfg_ff.decay_factor     <= DECAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_P_GAIN:           cfg_ff.p_gain           <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_I_GAIN:           cfg_ff.i_gain           <= $signed(csr_wdata[GAIN_W-1:0]);
            CSR_RUDDER_CENTRE:    cfg_ff.rudder_centre    <= csr_wdata[CENTRE_W-1:0];
            CSR_DEFLECTION_LIMIT: cfg_ff.deflection_limit <= csr_wdata[LIMIT_W-1:0];
            CSR_DECAY_FACTOR:     cfg_ff.decay_factor     <= csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   hpr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (s1_item_ff),
      .advance (s1_fire),
      .p_prod  (p_prod_in),
      .i_prod  (i_prod_in)
   );

   hpr_back u_back (
      .cfg    (cfg_ff),
      .p_prod (p_prod_ff),
      .i_prod (i_prod_ff),
      .result (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
      if (req_valid && req_ready) begin
         s1_item_ff <= req;
      end
      if (s1_fire) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
      end
      if (s2_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   `HPR_ASSERT(a_ready_when_empty, clock, reset, !s1_valid_ff |-> req_ready)
   `HPR_ASSERT(a_drain, clock, reset, (rsp_valid && rsp_ready && !s2_valid_ff) |=> !rsp_valid)
   `HPR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid_ff && !s1_valid_ff))

endmodule

// File: dv/heading_pi_rudder_controller_checker.sv
`timescale 1ns / 100ps

module heading_pi_rudder_controller_checker
   import hpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count,
   output int                     result_count
);

   logic signed [GAIN_W-1:0]  p_gain;
   logic signed [GAIN_W-1:0]  i_gain;
   logic [CENTRE_W-1:0]       centre;
   logic [LIMIT_W-1:0]        limit;
   logic [DECAY_W-1:0]        decay;
   logic signed [INTEG_W-1:0] integral;

   rsp_type rudder_due[$];

   function automatic logic signed [INTEG_W-1:0] clip_integral(input longint v);
      if (v > longint'(INTEG_MAX)) return INTEG_MAX;
      if (v < longint'(INTEG_MIN)) return INTEG_MIN;
      return INTEG_W'(v);
   endfunction

   // one control update: wraps the error, updates the leaky integrator
   function automatic rsp_type steer(input req_type r);
      longint  diff, err, drive, mag, rnd, angle, hi, lo, prod;
      rsp_type o;
      diff = longint'(r.target_heading) - longint'(r.measured_heading);
      if (diff > 180) diff = diff - 360;
      else if (diff < -180) diff = diff + 360;
      err = -diff;
      integral = clip_integral(longint'(integral) + err * 256);

      drive = longint'(p_gain) * err * 256 + longint'(i_gain) * longint'(integral);
      mag = (drive < 0) ? -drive : drive;
      rnd = (mag + 32768) / 65536;
      if (drive < 0) rnd = -rnd;

      o.limited = 1'b0;
      angle = longint'(centre) + rnd;
      hi = longint'(centre) + longint'(limit);
      lo = longint'(centre) - longint'(limit);
      if (lo < 0) lo = 0;
      if (angle > hi) begin
         angle = hi;
         o.limited = 1'b1;
      end else if (angle < lo) begin
         angle = lo;
         o.limited = 1'b1;
      end
      o.rudder_angle = ANGLE_W'(angle);

      // leak truncates toward zero
      prod = longint'(integral) * longint'(decay);
      mag = ((prod < 0) ? -prod : prod) / 256;
      integral = clip_integral((prod < 0) ? -mag : mag);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         p_gain = P_GAIN_RST;
         i_gain = I_GAIN_RST;
         centre = CENTRE_RST;
         limit = LIMIT_RST;
         decay = DECAY_RST;
         integral = '0;
         rudder_due.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_P_GAIN:           p_gain = csr_wdata;
               CSR_I_GAIN:           i_gain = csr_wdata;
               CSR_RUDDER_CENTRE:    centre = csr_wdata[CENTRE_W-1:0];
               CSR_DEFLECTION_LIMIT: limit = csr_wdata[LIMIT_W-1:0];
               CSR_DECAY_FACTOR:     decay = csr_wdata[DECAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) rudder_due.push_back(steer(req));
         if (rsp_valid && rsp_ready) begin
            if (rudder_due.size() == 0) begin
               $error("unexpected rudder item: rudder_angle %0d limited %0d",
                      rsp.rudder_angle, rsp.limited);
               error_count++;
            end else begin
               want = rudder_due.pop_front();
               result_count++;
               if (rsp.rudder_angle !== want.rudder_angle) begin
                  $error("rudder_angle: expected %0d, actual %0d",
                         want.rudder_angle, rsp.rudder_angle);
                  error_count++;
               end
               if (rsp.limited !== want.limited) begin
                  $error("limited: expected %0d, actual %0d", want.limited, rsp.limited);
                  error_count++;
               end
            end
         end
      end
      pending_count = rudder_due.size();
   end

endmodule

// File: dv/heading_pi_rudder_controller_tb.sv
`timescale 1ns / 100ps

module heading_pi_rudder_controller_tb;
   import hpr_pkg::*;

   localparam int CSR_COUNT     = 5;
   localparam int IDLE_PCT      = 35;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 58;
   localparam int DIRECTED      = 22;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   calm = 1'b0;

   int error_count;
   int pending_count;
   int result_count;
   int sent = 0;

   // wrap edges, +-180, headings above 359, repeated error to load the integrator
   int dir_meas[DIRECTED] = '{0, 359, 0, 359, 0, 180, 0, 181, 179, 0, 511,
                              0, 511, 360, 0, 511, 0, 0, 0, 0, 90, 270};
   int dir_targ[DIRECTED] = '{0, 359, 359, 0, 180, 0, 181, 0, 0, 179, 0,
                              511, 511, 0, 360, 151, 180, 180, 180, 180, 270, 90};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   heading_pi_rudder_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   heading_pi_rudder_controller_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req           (req),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic offer(input req_type r);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // hold the sender until every rudder item has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] pv, iv, cv, lv, dv);
      put_reg(CSR_P_GAIN, pv);
      put_reg(CSR_I_GAIN, iv);
      put_reg(CSR_RUDDER_CENTRE, cv);
      put_reg(CSR_DEFLECTION_LIMIT, lv);
      put_reg(CSR_DECAY_FACTOR, dv);
      // unmapped index, must be ignored
      put_reg(CSR_INDEX_W'($urandom_range(CSR_COUNT, 2**CSR_INDEX_W - 1)),
              CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      if ($urandom_range(1)) return CSR_DATA_W'($urandom);
      return CSR_DATA_W'($urandom_range(0, 1024) - 512);
   endfunction

   function automatic req_type pick_heading(input int bias);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.measured_heading = HEADING_W'($urandom_range(0, 359));
      if (pick < 60) begin
         r.target_heading = HEADING_W'($urandom_range(0, 359));
      end else if (pick < 85) begin
         r.target_heading = HEADING_W'((int'(r.measured_heading) + bias + 720
                                        + $urandom_range(0, 6) - 3) % 360);
      end else begin
         r.measured_heading = HEADING_W'($urandom_range(0, 511));
         r.target_heading = HEADING_W'($urandom_range(0, 511));
      end
      return r;
   endfunction

   initial begin
      int bias;
      req_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED; k++) begin
         r.measured_heading = HEADING_W'(dir_meas[k]);
         r.target_heading = HEADING_W'(dir_targ[k]);
         offer(r);
      end
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: program_regs(16'h7FFF, 16'h7FFF, 16'd180, 16'd90, 16'd256);
            1: program_regs(16'h8000, 16'h8000, 16'd0, 16'd90, 16'd0);
            2: program_regs(16'd256, 16'd26, 16'd90, 16'd0, 16'd243);
            3: program_regs(16'd0, 16'd1, 16'd90, 16'd90, 16'd511);
            4: program_regs(16'hFC00, 16'd0, 16'd20, 16'd90, 16'd128);
            default: begin
               if ($urandom_range(2) != 0)
                  program_regs(pick_gain(), pick_gain(),
                               CSR_DATA_W'($urandom_range(0, 180)),
                               CSR_DATA_W'($urandom_range(0, 90)),
                               CSR_DATA_W'($urandom_range(0, 256)));
               else
                  program_regs(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                               CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                               CSR_DATA_W'($urandom));
            end
         endcase
         if (ph == 6) calm <= 1'b1;
         bias = $urandom_range(0, 360) - 180;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            offer(pick_heading(bias));
            if ($urandom_range(49) == 0) settle();
         end
         settle();
         calm <= 1'b0;
      end

      repeat (10) @(posedge clock);
      $display("run covered %0d heading items, %0d rudder items checked", sent, result_count);
      $display("over %0d register settings incl. gain, centre, limit and decay extremes",
               PHASES + 1);
      if (error_count == 0 && pending_count == 0) begin
         $display("heading_pi_rudder_controller_tb: clean");
      end else begin
         $display("heading_pi_rudder_controller_tb: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("heading_pi_rudder_controller_tb: errors");
      $finish;
   end

endmodule
